@@ src/nested_region_self_time_profiler_macros.svh @@
// ----------------------------------------------------------------------------
// Nested region profiler assertion macros
// Concurrent assertion helpers clocked on clk and disabled while arst_n is low.
// Both forms compile to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef NESTED_REGION_SELF_TIME_PROFILER_MACROS_SVH
`define NESTED_REGION_SELF_TIME_PROFILER_MACROS_SVH
`ifndef SYNTH
`define NRP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define NRP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define NRP_ASSERT_IMP(lbl, ante, cons, msg)
`define NRP_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

@@ src/nrp_pkg.sv @@
// ----------------------------------------------------------------------------
// Nested region profiler package
// Request codes, status codes, field widths and the records held in memory.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nrp_pkg;

	localparam int DEF_MAX_DEPTH   = 64;
	localparam int DEF_NUM_REGIONS = 256;

	localparam int REGION_W = 8;
	localparam int DEPTH_W  = 7;
	localparam int VAL_W    = 64;

	typedef enum logic [1:0] {
		OP_ENTER = 2'd0,
		OP_EXIT  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic [REGION_W-1:0] region;
		logic [VAL_W-1:0]    start_ns;
		logic [VAL_W-1:0]    start_ops;
	} frame_t;

	typedef struct packed {
		logic [VAL_W-1:0] ns;
		logic [VAL_W-1:0] ops;
	} sum_t;

	typedef struct packed {
		logic rd_en;
		logic wr_frame;
		logic wr_child;
	} stk_ctl_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic clear;
	} tbl_ctl_t;

endpackage

@@ src/nrp_req_if.sv @@
// ----------------------------------------------------------------------------
// Nested region profiler request channel
// Valid/ready channel that carries one profiling request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface nrp_req_if;
	import nrp_pkg::*;

	logic                valid;
	logic                ready;
	op_t                 op;
	logic [REGION_W-1:0] region_id;
	logic [VAL_W-1:0]    time_ns;
	logic [VAL_W-1:0]    instr_count;

	modport source (output valid, op, region_id, time_ns, instr_count, input ready);
	modport sink (input valid, op, region_id, time_ns, instr_count, output ready);
endinterface

@@ src/nrp_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Nested region profiler response channel
// Valid/ready channel that carries the result of one request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface nrp_rsp_if;
	import nrp_pkg::*;

	logic                valid;
	logic                ready;
	status_t             status;
	logic [DEPTH_W-1:0]  stack_depth;
	logic [VAL_W-1:0]    nanos_value;
	logic [VAL_W-1:0]    ops_value;
	logic [REGION_W-1:0] exit_region;

	modport source (output valid, status, stack_depth, nanos_value, ops_value, exit_region,
		input ready);
	modport sink (input valid, status, stack_depth, nanos_value, ops_value, exit_region,
		output ready);
endinterface

@@ src/nrp_stack.sv @@
// ----------------------------------------------------------------------------
// Nested region profiler frame stack
// Frame memory with one write port and two registered read ports: the top
// frame with its child sums, and the child sums of the frame below it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nrp_stack #(
	parameter int MAX_DEPTH = 64
) (
	input  logic                                             clk,
	input  nrp_pkg::stk_ctl_t                                ctl,
	input  logic [((MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1)-1:0] rd_addr_a,
	input  logic [((MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1)-1:0] rd_addr_b,
	input  logic [((MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1)-1:0] wr_addr,
	input  nrp_pkg::frame_t                                  wr_frame,
	input  nrp_pkg::sum_t                                    wr_child,
	output nrp_pkg::frame_t                                  top_frame,
	output nrp_pkg::sum_t                                    top_child,
	output nrp_pkg::sum_t                                    par_child
);
	import nrp_pkg::*;

	frame_t frame_mem [MAX_DEPTH];
	sum_t   child_mem [MAX_DEPTH];

	frame_t top_frame_q;
	sum_t   top_child_q;
	sum_t   par_child_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_frame) begin
			frame_mem[wr_addr] <= wr_frame;
		end
		if (ctl.wr_child) begin
			child_mem[wr_addr] <= wr_child;
		end
		if (ctl.rd_en) begin
			top_frame_q <= frame_mem[rd_addr_a];
			top_child_q <= child_mem[rd_addr_a];
			par_child_q <= child_mem[rd_addr_b];
		end
	end

	assign top_frame = top_frame_q;
	assign top_child = top_child_q;
	assign par_child = par_child_q;
endmodule

@@ src/nrp_table.sv @@
// ----------------------------------------------------------------------------
// Nested region profiler statistics table
// Per-region totals in a memory with a registered read port, and one valid
// flag per region that clear drops all at once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nrp_table #(
	parameter int NUM_REGIONS = 256
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  nrp_pkg::tbl_ctl_t              ctl,
	input  logic [$clog2(NUM_REGIONS)-1:0] rd_addr,
	input  logic [$clog2(NUM_REGIONS)-1:0] wr_addr,
	input  nrp_pkg::sum_t                  wr_data,
	output nrp_pkg::sum_t                  rd_data,
	output logic                           rd_valid
);
	import nrp_pkg::*;

	sum_t                   total_mem [NUM_REGIONS];
	logic [NUM_REGIONS-1:0] valid_q;
	sum_t                   rd_data_q;
	logic                   rd_valid_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			total_mem[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_data_q <= total_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (ctl.clear) begin
				valid_q <= '0;
			end else if (ctl.wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (ctl.rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data  = rd_data_q;
	assign rd_valid = rd_valid_q;
endmodule

@@ src/nested_region_self_time_profiler.sv @@
// ----------------------------------------------------------------------------
// Nested region self-time profiler
// After accept, enter, clear and dropped requests go straight to S_OUT, a read
// passes through S_READ and an exit through S_EX1, S_EX2 and S_EX3; S_OUT loads
// the response register once the previous response has left it or is taken.
// No new request is taken until then. Reset empties the stack and marks every region invalid at once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "nested_region_self_time_profiler_macros.svh"

module nested_region_self_time_profiler #(
	parameter int MAX_DEPTH   = nrp_pkg::DEF_MAX_DEPTH,
	parameter int NUM_REGIONS = nrp_pkg::DEF_NUM_REGIONS
) (
	input logic       clk,
	input logic       arst_n,
	nrp_req_if.sink   req,
	nrp_rsp_if.source rsp
);
	import nrp_pkg::*;

	localparam int DW = $clog2(MAX_DEPTH + 1);
	localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
	localparam int RW = $clog2(NUM_REGIONS);

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_EX1,
		S_EX2,
		S_EX3,
		S_OUT
	} state_t;

	state_t              state_q;
	logic [DW-1:0]       depth_q;
	status_t             res_status_q;
	logic [VAL_W-1:0]    res_nanos_q;
	logic [VAL_W-1:0]    res_ops_q;
	logic [REGION_W-1:0] res_region_q;
	logic                rsp_valid_q;
	status_t             rsp_status_q;
	logic [DEPTH_W-1:0]  rsp_depth_q;
	logic [VAL_W-1:0]    rsp_nanos_q;
	logic [VAL_W-1:0]    rsp_ops_q;
	logic [REGION_W-1:0] rsp_region_q;

	logic [REGION_W-1:0] rid_q;
	logic [VAL_W-1:0]    now_ns_q;
	logic [VAL_W-1:0]    now_ops_q;
	logic [VAL_W-1:0]    el_ns_q;
	logic [VAL_W-1:0]    el_ops_q;
	logic [VAL_W-1:0]    self_ns_q;
	logic [VAL_W-1:0]    self_ops_q;
	logic [REGION_W-1:0] region_q;
	logic                has_parent_q;

	logic          acc;
	logic          rsp_load;
	logic          full;
	logic          empty;
	logic [DW-1:0] depth_m1;
	logic [DW-1:0] depth_m2;
	logic [15:0]   depth_x;
	logic [15:0]   req_rid_x;
	logic [15:0]   rid_x;
	logic [15:0]   region_x;
	logic          rid_in_range;
	logic          region_in_range;

	stk_ctl_t      stk_ctl;
	logic [AW-1:0] stk_wr_addr;
	frame_t        stk_wr_frame;
	sum_t          stk_wr_child;
	frame_t        top_frame;
	sum_t          top_child;
	sum_t          par_child;

	tbl_ctl_t      tbl_ctl;
	logic [RW-1:0] tbl_rd_addr;
	sum_t          tbl_wr_data;
	sum_t          tbl_rd_data;
	logic          tbl_rd_valid;

	assign acc       = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign rsp_load  = (state_q == S_OUT) && (!rsp_valid_q || rsp.ready);
	assign full      = (depth_q == DW'(MAX_DEPTH));
	assign empty     = (depth_q == '0);
	assign depth_m1  = depth_q - DW'(1);
	assign depth_m2  = depth_q - DW'(2);
	assign depth_x   = 16'(depth_q);

	assign req_rid_x       = 16'(req.region_id);
	assign rid_x           = 16'(rid_q);
	assign region_x        = 16'(region_q);
	assign rid_in_range    = (rid_x < 16'(NUM_REGIONS));
	assign region_in_range = (region_x < 16'(NUM_REGIONS));

	always_comb begin
		stk_ctl.rd_en    = acc && (req.op == OP_EXIT) && !empty;
		stk_ctl.wr_frame = acc && (req.op == OP_ENTER) && !full;
		stk_ctl.wr_child = stk_ctl.wr_frame || ((state_q == S_EX2) && has_parent_q);
		if (state_q == S_EX2) begin
			stk_wr_addr      = depth_m1[AW-1:0];
			stk_wr_child.ns  = par_child.ns + el_ns_q;
			stk_wr_child.ops = par_child.ops + el_ops_q;
		end else begin
			stk_wr_addr  = depth_q[AW-1:0];
			stk_wr_child = '0;
		end
		stk_wr_frame.region    = req.region_id;
		stk_wr_frame.start_ns  = req.time_ns;
		stk_wr_frame.start_ops = req.instr_count;
	end

	always_comb begin
		tbl_ctl.rd_en = (acc && (req.op == OP_READ)) || (state_q == S_EX2);
		tbl_ctl.wr_en = (state_q == S_EX3) && region_in_range;
		tbl_ctl.clear = acc && (req.op == OP_CLEAR);
		tbl_rd_addr   = (state_q == S_EX2) ? region_x[RW-1:0] : req_rid_x[RW-1:0];
		if (tbl_rd_valid) begin
			tbl_wr_data.ns  = tbl_rd_data.ns + self_ns_q;
			tbl_wr_data.ops = tbl_rd_data.ops + self_ops_q;
		end else begin
			tbl_wr_data.ns  = self_ns_q;
			tbl_wr_data.ops = self_ops_q;
		end
	end

	nrp_stack #(
		.MAX_DEPTH (MAX_DEPTH)
	) u_stack (
		.clk       (clk),
		.ctl       (stk_ctl),
		.rd_addr_a (depth_m1[AW-1:0]),
		.rd_addr_b (depth_m2[AW-1:0]),
		.wr_addr   (stk_wr_addr),
		.wr_frame  (stk_wr_frame),
		.wr_child  (stk_wr_child),
		.top_frame (top_frame),
		.top_child (top_child),
		.par_child (par_child)
	);

	nrp_table #(
		.NUM_REGIONS (NUM_REGIONS)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (tbl_ctl),
		.rd_addr  (tbl_rd_addr),
		.wr_addr  (region_x[RW-1:0]),
		.wr_data  (tbl_wr_data),
		.rd_data  (tbl_rd_data),
		.rd_valid (tbl_rd_valid)
	);

	always_ff @(posedge clk) begin
		if (acc) begin
			rid_q     <= req.region_id;
			now_ns_q  <= req.time_ns;
			now_ops_q <= req.instr_count;
		end
		if (state_q == S_EX1) begin
			el_ns_q      <= now_ns_q - top_frame.start_ns;
			el_ops_q     <= now_ops_q - top_frame.start_ops;
			region_q     <= top_frame.region;
			has_parent_q <= !empty;
		end
		if (state_q == S_EX2) begin
			self_ns_q  <= (el_ns_q > top_child.ns) ? el_ns_q - top_child.ns : '0;
			self_ops_q <= (el_ops_q > top_child.ops) ? el_ops_q - top_child.ops : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			depth_q      <= '0;
			res_status_q <= ST_DONE;
			res_nanos_q  <= '0;
			res_ops_q    <= '0;
			res_region_q <= '0;
			rsp_valid_q  <= 1'b0;
			rsp_status_q <= ST_DONE;
			rsp_depth_q  <= '0;
			rsp_nanos_q  <= '0;
			rsp_ops_q    <= '0;
			rsp_region_q <= '0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						res_nanos_q  <= '0;
						res_ops_q    <= '0;
						res_region_q <= req.region_id;
						case (req.op)
							OP_ENTER: begin
								if (full) begin
									res_status_q <= ST_FULL;
								end else begin
									res_status_q <= ST_DONE;
									depth_q      <= depth_q + DW'(1);
								end
								state_q <= S_OUT;
							end
							OP_EXIT: begin
								if (empty) begin
									res_status_q <= ST_EMPTY;
									state_q      <= S_OUT;
								end else begin
									res_status_q <= ST_DONE;
									depth_q      <= depth_m1;
									state_q      <= S_EX1;
								end
							end
							OP_CLEAR: begin
								res_status_q <= ST_DONE;
								state_q      <= S_OUT;
							end
							OP_READ: begin
								res_status_q <= ST_DONE;
								state_q      <= S_READ;
							end
							default: begin
								res_status_q <= ST_DONE;
								state_q      <= S_OUT;
							end
						endcase
					end
				end
				S_READ: begin
					if (rid_in_range && tbl_rd_valid) begin
						res_nanos_q <= tbl_rd_data.ns;
						res_ops_q   <= tbl_rd_data.ops;
					end
					state_q <= S_OUT;
				end
				S_EX1: begin
					state_q <= S_EX2;
				end
				S_EX2: begin
					state_q <= S_EX3;
				end
				S_EX3: begin
					res_nanos_q  <= self_ns_q;
					res_ops_q    <= self_ops_q;
					res_region_q <= region_q;
					state_q      <= S_OUT;
				end
				S_OUT: begin
					if (rsp_load) begin
						rsp_status_q <= res_status_q;
						rsp_depth_q  <= depth_x[DEPTH_W-1:0];
						rsp_nanos_q  <= res_nanos_q;
						rsp_ops_q    <= res_ops_q;
						rsp_region_q <= res_region_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.stack_depth = rsp_depth_q;
	assign rsp.nanos_value = rsp_nanos_q;
	assign rsp.ops_value   = rsp_ops_q;
	assign rsp.exit_region = rsp_region_q;

	`NRP_ASSERT_IMP(a_depth_bound, 1'b1, depth_q <= DW'(MAX_DEPTH), "stack depth beyond limit")
	`NRP_ASSERT_NXT(a_exit_pop, acc && (req.op == OP_EXIT) && !empty, depth_q == $past(depth_q) - DW'(1), "exit did not pop one frame")
	`NRP_ASSERT_NXT(a_full_hold, acc && (req.op == OP_ENTER) && full, $stable(depth_q), "dropped enter changed the depth")
endmodule

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// Nested region self-time profiler testbench
// Drives enter, exit, clear and read requests through the request channel and
// predicts every response with a private copy of the region stack and the
// totals table. Responses are compared field by field in order, under random
// sender bursts, receiver stalls, a long receiver hold-off and full drains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import nrp_pkg::*;

	localparam int STACK_DEPTH    = DEF_MAX_DEPTH;
	localparam int STACK_AW       = $clog2(STACK_DEPTH);
	localparam int TABLE_SIZE     = DEF_NUM_REGIONS;
	localparam int RANDOM_EVENTS  = 1400;
	localparam int HOLD_OFF_SPAN  = 300;
	localparam int DRAIN_SLACK    = 8;
	localparam int WATCHDOG_LIMIT = 3000;

	typedef struct {
		status_t             status;
		logic [DEPTH_W-1:0]  depth;
		logic [VAL_W-1:0]    ns;
		logic [VAL_W-1:0]    ops;
		logic [REGION_W-1:0] region;
	} result_t;

	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PATTERN
	} stall_t;

	logic clk = 1'b0;
	logic arst_n;

	nrp_req_if req ();
	nrp_rsp_if rsp ();

	nested_region_self_time_profiler i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	logic [REGION_W-1:0] frm_region    [STACK_DEPTH];
	logic [VAL_W-1:0]    frm_start_ns  [STACK_DEPTH];
	logic [VAL_W-1:0]    frm_child_ns  [STACK_DEPTH];
	logic [VAL_W-1:0]    frm_start_ops [STACK_DEPTH];
	logic [VAL_W-1:0]    frm_child_ops [STACK_DEPTH];
	int                  open_depth = 0;
	logic [VAL_W-1:0]    region_ns  [TABLE_SIZE];
	logic [VAL_W-1:0]    region_ops [TABLE_SIZE];
	bit                  region_seen [TABLE_SIZE];

	result_t          pending_results [$];
	int unsigned      mismatches = 0;
	int unsigned      burst_left = 0;
	int unsigned      hold_request = 0;
	int unsigned      quiet_cycles = 0;
	logic [VAL_W-1:0] clock_ns = '0;
	logic [VAL_W-1:0] clock_ops = '0;

	function automatic result_t profile_event(op_t o, logic [REGION_W-1:0] rid,
		logic [VAL_W-1:0] t, logic [VAL_W-1:0] ic);
		result_t             r;
		logic [VAL_W-1:0]    el_ns;
		logic [VAL_W-1:0]    el_ops;
		int                  top;
		logic [STACK_AW-1:0] slot;
		logic [STACK_AW-1:0] up;
		r.status = ST_DONE;
		r.ns = '0;
		r.ops = '0;
		r.region = rid;
		case (o)
			OP_ENTER: begin
				if (open_depth >= STACK_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					slot = STACK_AW'(open_depth);
					frm_region[slot] = rid;
					frm_start_ns[slot] = t;
					frm_child_ns[slot] = '0;
					frm_start_ops[slot] = ic;
					frm_child_ops[slot] = '0;
					open_depth++;
				end
			end
			OP_EXIT: begin
				if (open_depth == 0) begin
					r.status = ST_EMPTY;
				end else begin
					top = open_depth - 1;
					slot = STACK_AW'(top);
					el_ns = t - frm_start_ns[slot];
					el_ops = ic - frm_start_ops[slot];
					r.ns = (el_ns > frm_child_ns[slot]) ? el_ns - frm_child_ns[slot] : '0;
					r.ops = (el_ops > frm_child_ops[slot]) ? el_ops - frm_child_ops[slot] : '0;
					r.region = frm_region[slot];
					open_depth = top;
					if (r.region < TABLE_SIZE) begin
						if (region_seen[r.region]) begin
							region_ns[r.region] += r.ns;
							region_ops[r.region] += r.ops;
						end else begin
							region_ns[r.region] = r.ns;
							region_ops[r.region] = r.ops;
							region_seen[r.region] = 1'b1;
						end
					end
					if (top > 0) begin
						up = STACK_AW'(top - 1);
						frm_child_ns[up] += el_ns;
						frm_child_ops[up] += el_ops;
					end
				end
			end
			OP_CLEAR: begin
				foreach (region_seen[i])
					region_seen[i] = 1'b0;
			end
			OP_READ: begin
				if (rid < TABLE_SIZE && region_seen[rid]) begin
					r.ns = region_ns[rid];
					r.ops = region_ops[rid];
				end
			end
		endcase
		r.depth = open_depth[DEPTH_W-1:0];
		return r;
	endfunction

	function automatic logic [VAL_W-1:0] advance_ns(int unsigned span);
		clock_ns += VAL_W'(span);
		return clock_ns;
	endfunction

	function automatic logic [VAL_W-1:0] advance_ops(int unsigned span);
		clock_ops += VAL_W'(span);
		return clock_ops;
	endfunction

	task automatic send_request(input op_t o, input logic [REGION_W-1:0] rid,
		input logic [VAL_W-1:0] t, input logic [VAL_W-1:0] ic);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 6);
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 8);
		end
		burst_left--;
		req.valid <= 1'b1;
		req.op <= o;
		req.region_id <= rid;
		req.time_ns <= t;
		req.instr_count <= ic;
		do
			@(posedge clk);
		while (req.ready !== 1'b1);
		pending_results.push_back(profile_event(o, rid, t, ic));
	endtask

	task automatic pause_until_drained();
		req.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_SLACK) @(posedge clk);
	endtask

	task automatic random_item(input int unsigned climb_pct);
		op_t                 o;
		int unsigned         roll;
		logic [REGION_W-1:0] rid;
		logic [VAL_W-1:0]    t;
		logic [VAL_W-1:0]    ic;
		roll = $urandom_range(0, 99);
		if (roll < 2)
			o = OP_CLEAR;
		else if (roll < 14)
			o = OP_READ;
		else if ($urandom_range(0, 99) < climb_pct)
			o = OP_ENTER;
		else
			o = OP_EXIT;
		rid = ($urandom_range(0, 3) == 0) ? REGION_W'($urandom_range(0, 255))
			: REGION_W'($urandom_range(0, 11));
		roll = $urandom_range(0, 39);
		if (roll == 0)
			clock_ns = {$urandom, $urandom};
		else if (roll == 1)
			clock_ns = '1 - VAL_W'($urandom_range(0, 20000));
		t = advance_ns($urandom_range(0, 5000));
		roll = $urandom_range(0, 39);
		if (roll == 0)
			clock_ops = {$urandom, $urandom};
		else if (roll == 1)
			clock_ops = '1 - VAL_W'($urandom_range(0, 20000));
		ic = advance_ops($urandom_range(0, 3000));
		send_request(o, rid, t, ic);
	endtask

	task automatic test_directed();
		send_request(OP_EXIT, 8'hFF, '1, '1);
		send_request(OP_READ, 8'h00, '0, '0);
		send_request(OP_READ, 8'hFF, '1, '1);
		send_request(OP_ENTER, 8'h00, 64'd0, 64'd0);
		send_request(OP_ENTER, 8'hFF, 64'd100, 64'd10);
		send_request(OP_EXIT, 8'h5A, 64'd350, 64'd40);
		send_request(OP_EXIT, 8'hA5, 64'd1000, 64'd100);
		send_request(OP_READ, 8'h00, 64'd1100, 64'd110);
		send_request(OP_READ, 8'hFF, 64'd1100, 64'd110);
		send_request(OP_ENTER, 8'h02, 64'd1000, 64'd200);
		send_request(OP_ENTER, 8'h03, 64'd1000, 64'd200);
		send_request(OP_EXIT, 8'h00, 64'd5000, 64'd900);
		send_request(OP_EXIT, 8'h00, 64'd2000, 64'd300);
		send_request(OP_READ, 8'h02, 64'd2000, 64'd300);
		send_request(OP_ENTER, 8'h04, 64'hFFFF_FFFF_FFFF_FFF6, 64'd1000);
		send_request(OP_EXIT, 8'h00, 64'd20, 64'd5);
		send_request(OP_READ, 8'h04, 64'd30, 64'd6);
		send_request(OP_CLEAR, 8'h77, '1, '1);
		send_request(OP_READ, 8'h00, 64'd40, 64'd7);
		send_request(OP_READ, 8'hFF, 64'd40, 64'd7);
		send_request(OP_ENTER, 8'h00, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
		send_request(OP_EXIT, 8'h00, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
		send_request(OP_READ, 8'h00, '0, '0);
		send_request(OP_CLEAR, 8'h00, '0, '0);
	endtask

	task automatic test_stack_full();
		while (open_depth < STACK_DEPTH)
			send_request(OP_ENTER, REGION_W'($urandom_range(0, 255)),
				advance_ns($urandom_range(0, 500)), advance_ops($urandom_range(0, 300)));
		repeat (2)
			send_request(OP_ENTER, REGION_W'($urandom_range(0, 255)), advance_ns(10),
				advance_ops(10));
		send_request(OP_READ, REGION_W'($urandom_range(0, 255)), advance_ns(10),
			advance_ops(10));
		while (open_depth > 0)
			send_request(OP_EXIT, REGION_W'($urandom_range(0, 255)),
				advance_ns($urandom_range(0, 900)), advance_ops($urandom_range(0, 600)));
		repeat (2)
			send_request(OP_EXIT, REGION_W'($urandom_range(0, 255)), advance_ns(10),
				advance_ops(10));
	endtask

	task automatic test_backpressure();
		hold_request = HOLD_OFF_SPAN;
		burst_left = 40;
		repeat (40)
			random_item(60);
	endtask

	task automatic test_drain();
		repeat (3) begin
			repeat (12)
				random_item(55);
			pause_until_drained();
		end
	endtask

	task automatic test_random();
		int unsigned climb_pct;
		climb_pct = 50;
		for (int n = 0; n < RANDOM_EVENTS; n++) begin
			if (n % 100 == 0)
				climb_pct = $urandom_range(25, 75);
			random_item(climb_pct);
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		req.valid <= 1'b0;
		req.op <= OP_ENTER;
		req.region_id <= '0;
		req.time_ns <= '0;
		req.instr_count <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_stack_full();
		test_backpressure();
		test_drain();
		test_random();
		pause_until_drained();
		if (mismatches == 0) begin
			$display("nested_region_self_time_profiler regression: pass");
		end else begin
			$display("nested_region_self_time_profiler regression: fail");
		end
		$finish;
	end

	initial begin : rsp_stall
		int unsigned hold_left;
		int unsigned mode_left;
		int unsigned phase;
		stall_t      mode;
		hold_left = 0;
		mode_left = 0;
		phase = 0;
		mode = STALL_NONE;
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request != 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp.ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode = stall_t'($urandom_range(0, 3));
					mode_left = $urandom_range(10, 80);
				end
				mode_left--;
				phase++;
				case (mode)
					STALL_NONE:    rsp.ready <= 1'b1;
					STALL_LIGHT:   rsp.ready <= ($urandom_range(0, 3) != 0);
					STALL_HEAVY:   rsp.ready <= ($urandom_range(0, 3) == 0);
					STALL_PATTERN: rsp.ready <= ((phase % 5) < 3);
				endcase
			end
		end
	end

	task automatic check_field(input string field, input logic [VAL_W-1:0] want,
		input logic [VAL_W-1:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
		end
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected response, expected none, actual status %0d depth %0d",
					$time, rsp.status, rsp.stack_depth);
			end else begin
				want = pending_results.pop_front();
				check_field("status", VAL_W'(want.status), VAL_W'(rsp.status));
				check_field("stack_depth", VAL_W'(want.depth), VAL_W'(rsp.stack_depth));
				check_field("nanos_value", want.ns, rsp.nanos_value);
				check_field("ops_value", want.ops, rsp.ops_value);
				check_field("exit_region", VAL_W'(want.region), VAL_W'(rsp.exit_region));
			end
		end
	end

	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("nested_region_self_time_profiler regression: fail");
			$finish;
		end
	end

endmodule
